// ===== hdl/frs_pkg.sv =====
// frs_pkg: shared types, constants and register map of the fault retry supervisor.
// Used by frs_cfg and fault_retry_supervisor; depends on nothing else.

package frs_pkg;

    // Sizing
    localparam int CHANNELS  = 14;
    localparam int LOG_DEPTH = 16;
    localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W    = $clog2(LOG_DEPTH);

    // Config port: 32-bit registers at 4*i
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_RETRY_LIMIT  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CLEAR_DELAY  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RESET_MASK   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LOG_BASE     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ENTRY_BYTES  = 3'd4;

    // Reset values
    localparam logic [7:0]          RETRY_LIMIT_RST = 8'd5;
    localparam logic [15:0]         CLEAR_DELAY_RST = 16'd5;
    localparam logic [CHANNELS-1:0] RESET_MASK_RST  = CHANNELS'(72);
    localparam logic [15:0]         LOG_BASE_RST    = 16'h0100;
    localparam logic [7:0]          ENTRY_BYTES_RST = 8'd16;

    typedef enum logic [1:0] {
        OP_POLL   = 2'd0,
        OP_HANDLE = 2'd1,
        OP_RAISE  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_DETECT    = 3'd1,
        ACT_CLEAR     = 3'd2,
        ACT_CYCLE     = 3'd3,
        ACT_RESETREQ  = 3'd4,
        ACT_DISABLE   = 3'd5,
        ACT_RESETFAIL = 3'd6
    } t_action;

    typedef struct packed {
        t_op         operation;
        logic [3:0]  channel;
        logic        pin_healthy;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        t_action     action;
        logic [3:0]  action_channel;
        logic [7:0]  retries_now;
        logic [3:0]  log_slot;
        logic [15:0] log_address;
    } t_out_item;

    typedef struct packed {
        logic [7:0]          retry_limit;
        logic [15:0]         clear_delay_ms;
        logic [CHANNELS-1:0] reset_request_mask;
        logic [15:0]         log_base_address;
        logic [7:0]          log_entry_bytes;
    } t_cfg;

endpackage

// ===== hdl/fault_retry_supervisor.sv =====
// fault_retry_supervisor: top level; per-channel fault state, retry decision and ring log.
// Depends on frs_pkg and frs_cfg.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall / i_in_data): one service transaction
//    per channel event: operation (poll, handle, raise), channel, pin level, ms time.
//  - Output channel (o_out_valid / i_out_stall / o_out_data): exactly one result
//    transaction per input transaction, in order: action, channel, retry count,
//    log slot and EEPROM address of the log entry.
//  - Config port: APB-style, pready tied high, registers at byte address 4*i.
//    Write only while no transaction is in flight.
//  - Flow: an accepted transaction lands in the input register, is evaluated
//    from there and its result is captured in the result register.
//  - Throughput: one transaction per cycle while the output is not stalled. The
//    state read-modify-write of the addressed channel (one 32-bit time subtract
//    and compare, 8-bit retry compare) completes in the evaluate cycle, so
//    back-to-back events on the same channel see each other's update with no bubble.
//  - Stall: when the result register is full and i_out_stall is high the evaluate
//    step holds; o_in_stall rises only once the input register is full as well.
//    Nothing is dropped or repeated.
//  - Reset (synchronous, active low): all channels inactive with zero retry count
//    and zero timestamp, log pointer at slot zero, registers at default values,
//    both pipeline registers empty. No clearing sweep is needed.

module fault_retry_supervisor (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input transactions
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  frs_pkg::t_in_item           i_in_data,
    // result transactions
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output frs_pkg::t_out_item          o_out_data,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [frs_pkg::ADDR_W-1:0]  paddr,
    input  logic [frs_pkg::DATA_W-1:0]  pwdata,
    output logic [frs_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    localparam int CH  = frs_pkg::CHANNELS;
    localparam int IW  = frs_pkg::CH_IDX_W;
    localparam int SW  = frs_pkg::SLOT_W;

    frs_pkg::t_cfg      w_cfg;

    // pipeline registers
    logic               r_in_valid;
    frs_pkg::t_in_item  r_in;
    logic               r_out_valid;
    frs_pkg::t_out_item r_out;
    logic               w_advance;
    logic               w_in_take;

    // per-channel state, one entry touched per cycle
    logic               r_active    [CH];
    logic [7:0]         r_retries   [CH];
    logic [31:0]        r_last_time [CH];
    logic [SW-1:0]      r_log_next;

    // evaluate-stage signals
    logic               w_in_range;
    logic               w_op_ok;
    logic [IW-1:0]      w_idx;
    logic               w_cur_active;
    logic [7:0]         w_cur_retries;
    logic [31:0]        w_cur_time;
    logic               w_use_reset;
    logic [31:0]        w_elapsed;
    logic [15:0]        w_prod;
    logic [SW-1:0]      w_slot_inc;
    logic [SW-1:0]      w_slot_prev;

    logic               w_wr;         // addressed channel entry is written
    logic               n_active;
    logic [7:0]         n_retries;
    logic [31:0]        n_last_time;
    logic [SW-1:0]      n_log_next;
    frs_pkg::t_out_item n_out;

    frs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // ---------------------------------------------------------------- handshake
    // Evaluate when an item waits and the result register is free or draining.
    assign w_advance   = r_in_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall  = r_in_valid & ~w_advance;
    assign w_in_take   = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------------------------------------------------------- state read
    assign w_in_range    = (32'(r_in.channel) < CH);
    assign w_op_ok       = (r_in.operation == frs_pkg::OP_POLL)
                         | (r_in.operation == frs_pkg::OP_HANDLE)
                         | (r_in.operation == frs_pkg::OP_RAISE);
    assign w_idx         = w_in_range ? IW'(r_in.channel) : '0;
    assign w_cur_active  = r_active[w_idx];
    assign w_cur_retries = r_retries[w_idx];
    assign w_cur_time    = r_last_time[w_idx];
    assign w_use_reset   = (r_in.operation == frs_pkg::OP_HANDLE)
                         & w_cfg.reset_request_mask[w_idx];
    assign w_elapsed     = r_in.now_ms - w_cur_time;        // wraps mod 2^32

    // ring log pointer neighbors
    assign w_slot_inc  = (r_log_next == SW'(frs_pkg::LOG_DEPTH - 1)) ? '0 : r_log_next + SW'(1);
    assign w_slot_prev = (r_log_next == '0) ? SW'(frs_pkg::LOG_DEPTH - 1) : r_log_next - SW'(1);

    // slot offset in EEPROM bytes, kept to 16 bits
    assign w_prod = 16'(r_log_next) * 16'(w_cfg.log_entry_bytes);

    // ---------------------------------------------------------------- decision
    always_comb begin
        w_wr        = 1'b0;
        n_active    = w_cur_active;
        n_retries   = w_cur_retries;
        n_last_time = w_cur_time;
        n_log_next  = r_log_next;

        n_out                = '0;
        n_out.action         = frs_pkg::ACT_NONE;
        n_out.action_channel = r_in.channel;

        if (w_in_range && w_op_ok) begin
            w_wr = 1'b1;
            if (!w_cur_active) begin
                // new fault: poll or raise only; handle ignores idle channels
                if (!r_in.pin_healthy && (r_in.operation != frs_pkg::OP_HANDLE)) begin
                    n_active          = 1'b1;
                    n_last_time       = r_in.now_ms;
                    n_log_next        = w_slot_inc;
                    n_out.action      = frs_pkg::ACT_DETECT;
                    n_out.log_slot    = 4'(r_log_next);
                    n_out.log_address = w_cfg.log_base_address + w_prod;
                end
            end else if (r_in.operation != frs_pkg::OP_RAISE) begin
                if (r_in.pin_healthy) begin
                    // pin recovered: clear once the delay has strictly passed
                    if (w_elapsed > 32'(w_cfg.clear_delay_ms)) begin
                        n_active       = 1'b0;
                        n_out.action   = frs_pkg::ACT_CLEAR;
                        n_out.log_slot = 4'(w_slot_prev);
                    end
                end else if (w_cur_retries < w_cfg.retry_limit) begin
                    n_retries    = w_cur_retries + 8'd1;
                    n_last_time  = r_in.now_ms;
                    n_out.action = w_use_reset ? frs_pkg::ACT_RESETREQ : frs_pkg::ACT_CYCLE;
                end else begin
                    // retries used up: give the channel up
                    n_active     = 1'b0;
                    n_out.action = w_use_reset ? frs_pkg::ACT_RESETFAIL
                                               : frs_pkg::ACT_DISABLE;
                end
            end
            n_out.retries_now = n_retries;
        end else if (w_in_range) begin
            // unknown operation: report the count, change nothing
            n_out.retries_now = w_cur_retries;
        end
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_log_next  <= '0;
            for (int i = 0; i < CH; i++) begin
                r_active[i]    <= 1'b0;
                r_retries[i]   <= '0;
                r_last_time[i] <= '0;
            end
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end

            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (w_advance) begin
                r_log_next <= n_log_next;
                if (w_wr) begin
                    r_active[w_idx]    <= n_active;
                    r_retries[w_idx]   <= n_retries;
                    r_last_time[w_idx] <= n_last_time;
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in <= i_in_data;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    // ---------------------------------------------------------------- assertions
    // A held result is never overwritten by a new evaluation.
    a_no_eval_while_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !w_advance)
        else $error("evaluation while result register is stalled");

    // A full input register takes a new item only as its own item moves on.
    a_in_reg_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_take && r_in_valid) |-> w_advance)
        else $error("input register overrun");

    // A detected channel is active afterwards.
    a_detect_sets_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (n_out.action == frs_pkg::ACT_DETECT)) |=> r_active[$past(w_idx)])
        else $error("detected channel not active");

    // The log pointer moves only on a detect.
    a_log_ptr_detect_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_advance && (n_out.action == frs_pkg::ACT_DETECT)) |=> $stable(r_log_next))
        else $error("log pointer moved without a detect");

endmodule

// ===== hdl/frs_cfg.sv =====
// frs_cfg: APB-style configuration register file of the fault retry supervisor.
// Depends on frs_pkg for the register map, reset values and t_cfg.

module frs_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [frs_pkg::ADDR_W-1:0]  paddr,
    input  logic [frs_pkg::DATA_W-1:0]  pwdata,
    output logic [frs_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output frs_pkg::t_cfg               o_cfg
);

    frs_pkg::t_cfg                  r_cfg;
    frs_pkg::t_cfg                  n_cfg;
    logic [frs_pkg::REG_IDX_W-1:0]  w_idx;
    logic                           w_wr;

    assign w_idx  = paddr[frs_pkg::ADDR_W-1:2];
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                frs_pkg::REG_RETRY_LIMIT: n_cfg.retry_limit        = pwdata[7:0];
                frs_pkg::REG_CLEAR_DELAY: n_cfg.clear_delay_ms     = pwdata[15:0];
                frs_pkg::REG_RESET_MASK:  n_cfg.reset_request_mask =
                                              pwdata[frs_pkg::CHANNELS-1:0];
                frs_pkg::REG_LOG_BASE:    n_cfg.log_base_address   = pwdata[15:0];
                frs_pkg::REG_ENTRY_BYTES: n_cfg.log_entry_bytes    = pwdata[7:0];
                default:                  n_cfg = r_cfg;   // unmapped: ignored
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            frs_pkg::REG_RETRY_LIMIT: prdata = frs_pkg::DATA_W'(r_cfg.retry_limit);
            frs_pkg::REG_CLEAR_DELAY: prdata = frs_pkg::DATA_W'(r_cfg.clear_delay_ms);
            frs_pkg::REG_RESET_MASK:  prdata = frs_pkg::DATA_W'(r_cfg.reset_request_mask);
            frs_pkg::REG_LOG_BASE:    prdata = frs_pkg::DATA_W'(r_cfg.log_base_address);
            frs_pkg::REG_ENTRY_BYTES: prdata = frs_pkg::DATA_W'(r_cfg.log_entry_bytes);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.retry_limit        <= frs_pkg::RETRY_LIMIT_RST;
            r_cfg.clear_delay_ms     <= frs_pkg::CLEAR_DELAY_RST;
            r_cfg.reset_request_mask <= frs_pkg::RESET_MASK_RST;
            r_cfg.log_base_address   <= frs_pkg::LOG_BASE_RST;
            r_cfg.log_entry_bytes    <= frs_pkg::ENTRY_BYTES_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule
